@@ rtl/tsp_pkg.sv @@
// Package for the triangular self product core.
// Holds the item codes, the sequencer state type and fixed field widths.
// No dependencies.
package tsp_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ORD_W  = 6;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned CFG_W  = 6;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_COMPUTE = 2'd1,
    OP_READ    = 2'd2
  } op_e;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic CFG_LOWER_MODE = 1'b0;
  localparam logic CFG_ORDER      = 1'b1;

  localparam logic [ORD_W-1:0] ORDER_RESET = 6'd32;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_WB    = 4'b1000
  } state_e;

endpackage

@@ rtl/triangular_self_product_core.sv @@
// Top level of the triangular self product core.
// Depends on tsp_pkg and tsp_ram.
//
// Write and read items are taken one per cycle while busy is low; a read answers in
// the cycle after it is taken, with kind 0. A compute item holds busy high while the
// sequencer walks the triangle: each element of column p (row p in lower mode) is
// formed by multiply steps over k from p to order - 1, a pipeline drain and one
// write-back, all through the single multiply-accumulate path fed from two copies of
// the element memory. The done item (kind 1) is strobed in the first cycle with busy
// low again; for an order of zero or above MAX_ORDER it follows in the next cycle and
// busy stays low. Results are strobed for exactly one cycle by valid_o.
module triangular_self_product_core #(
  parameter int unsigned MAX_ORDER = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [tsp_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  op_i,
  input  logic [tsp_pkg::POS_W-1:0]   row_i,
  input  logic [tsp_pkg::POS_W-1:0]   col_i,
  input  logic signed [tsp_pkg::DATA_W-1:0] value_i,
  output logic                        valid_o,
  output logic                        kind_o,
  output logic signed [tsp_pkg::DATA_W-1:0] data_o
);

  localparam int unsigned DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned ACC_W = 2 * tsp_pkg::DATA_W + $clog2(MAX_ORDER + 1) + 1;
  localparam int unsigned DW    = tsp_pkg::DATA_W;
  localparam int unsigned OW    = tsp_pkg::ORD_W;

  function automatic logic [AW-1:0] addr_of(input logic lower, input int unsigned r,
                                            input int unsigned c);
    int unsigned a;
    if (lower) a = c * MAX_ORDER + r;
    else       a = r * MAX_ORDER + c;
    return AW'(a);
  endfunction

  tsp_pkg::state_e state_q, state_d;
  logic            lower_q;
  logic [OW-1:0]   order_q;
  logic [OW-1:0]   p_q, p_d, q_q, q_d, k_q, k_d;
  logic            s1_q, s2_q, s1_d;
  logic signed [2*DW-1:0]  mul_q;
  logic signed [ACC_W-1:0] acc_q, acc_sh;
  logic            rd_pend_q, rd_ok_q, done_q, done_d;
  logic [AW-1:0]   raddr_a, raddr_b, waddr;
  logic            we;
  logic [DW-1:0]   wdata, rdata_a, rdata_b, sat;
  logic            accept, pos_ok, order_bad, last_k, last_p;
  tsp_pkg::op_e    op;

  assign busy      = (state_q != tsp_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign op        = tsp_pkg::op_e'(op_i);
  assign pos_ok    = (int'(row_i) < MAX_ORDER) && (int'(col_i) < MAX_ORDER);
  assign order_bad = (order_q == '0) || (int'(order_q) > MAX_ORDER);
  assign last_k    = (k_q == OW'(order_q - 1'b1));
  assign last_p    = (p_q == OW'(order_q - 1'b1));

  assign acc_sh = acc_q >>> FRAC_BITS;
  always_comb begin
    if (acc_sh > ACC_W'(32'sh7fff_ffff) && !acc_sh[ACC_W-1]) begin
      sat = 32'h7fff_ffff;
    end else if (acc_sh[ACC_W-1] && (acc_sh < -(ACC_W'(33'sh0_8000_0000)))) begin
      sat = 32'h8000_0000;
    end else begin
      sat = acc_sh[DW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    p_d     = p_q;
    q_d     = q_q;
    k_d     = k_q;
    s1_d    = 1'b0;
    done_d  = 1'b0;
    we      = 1'b0;
    waddr   = addr_of(1'b0, int'(row_i), int'(col_i));
    wdata   = value_i;
    raddr_a = addr_of(1'b0, int'(row_i), int'(col_i));
    raddr_b = addr_of(lower_q, int'(p_q), int'(k_q));
    unique case (state_q)
      tsp_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op)
            tsp_pkg::OP_WRITE: we = pos_ok;
            tsp_pkg::OP_COMPUTE: begin
              if (order_bad) begin
                done_d = 1'b1;
              end else begin
                state_d = tsp_pkg::ST_RUN;
                p_d = '0;
                q_d = '0;
                k_d = '0;
              end
            end
            default: ;
          endcase
        end
      end
      tsp_pkg::ST_RUN: begin
        raddr_a = addr_of(lower_q, int'(q_q), int'(k_q));
        s1_d    = 1'b1;
        k_d     = OW'(k_q + 1'b1);
        if (last_k) state_d = tsp_pkg::ST_DRAIN;
      end
      tsp_pkg::ST_DRAIN: begin
        if (!s1_q && !s2_q) state_d = tsp_pkg::ST_WB;
      end
      tsp_pkg::ST_WB: begin
        we    = 1'b1;
        waddr = addr_of(lower_q, int'(q_q), int'(p_q));
        wdata = sat;
        if (q_q == p_q) begin
          if (last_p) begin
            state_d = tsp_pkg::ST_IDLE;
            done_d  = 1'b1;
          end else begin
            state_d = tsp_pkg::ST_RUN;
            p_d = OW'(p_q + 1'b1);
            q_d = '0;
            k_d = OW'(p_q + 1'b1);
          end
        end else begin
          state_d = tsp_pkg::ST_RUN;
          q_d = OW'(q_q + 1'b1);
          k_d = p_q;
        end
      end
      default: state_d = tsp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tsp_pkg::ST_IDLE;
      lower_q   <= 1'b0;
      order_q   <= tsp_pkg::ORDER_RESET;
      p_q       <= '0;
      q_q       <= '0;
      k_q       <= '0;
      s1_q      <= 1'b0;
      s2_q      <= 1'b0;
      rd_pend_q <= 1'b0;
      rd_ok_q   <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      p_q       <= p_d;
      q_q       <= q_d;
      k_q       <= k_d;
      s1_q      <= s1_d;
      s2_q      <= s1_q;
      rd_pend_q <= accept && (op == tsp_pkg::OP_READ);
      rd_ok_q   <= pos_ok;
      done_q    <= done_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tsp_pkg::CFG_LOWER_MODE: lower_q <= cfg_data_i[0];
          tsp_pkg::CFG_ORDER:      order_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= $signed(rdata_a) * $signed(rdata_b);
    if (state_q == tsp_pkg::ST_WB || (state_q == tsp_pkg::ST_IDLE)) begin
      acc_q <= '0;
    end else if (s2_q) begin
      acc_q <= acc_q + ACC_W'(mul_q);
    end
  end

  tsp_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  tsp_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  assign valid_o = rd_pend_q || done_q;
  assign kind_o  = done_q ? tsp_pkg::KIND_DONE : tsp_pkg::KIND_READ;
  assign data_o  = (rd_pend_q && rd_ok_q) ? rdata_a : '0;

endmodule

@@ rtl/tsp_ram.sv @@
// Generic synchronous RAM with one write port and one registered read port.
// Used by the triangular self product core; no dependencies.
module tsp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ tb/tsp_checker.sv @@
`timescale 1ns / 1ps
// Checker for the triangular self product core: watches the config port, the item
// and result channels, predicts every result and compares. Depends on tsp_pkg.
module tsp_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [tsp_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              start,
  input  logic                              busy,
  input  logic [1:0]                        op_i,
  input  logic [tsp_pkg::POS_W-1:0]         row_i,
  input  logic [tsp_pkg::POS_W-1:0]         col_i,
  input  logic signed [tsp_pkg::DATA_W-1:0] value_i,
  input  logic                              valid_o,
  input  logic                              kind_o,
  input  logic signed [tsp_pkg::DATA_W-1:0] data_o,
  output int                                fail_count_o,
  output int                                pending_o
);

  localparam int unsigned MAX_ORDER = 32;
  localparam int unsigned FRAC_BITS = 16;

  typedef struct packed {
    logic                              kind;
    logic signed [tsp_pkg::DATA_W-1:0] data;
  } answer_t;

  answer_t                           answers_q[$];
  logic signed [tsp_pkg::DATA_W-1:0] elements [MAX_ORDER][MAX_ORDER];
  logic                              lower_mode;
  logic [tsp_pkg::ORD_W-1:0]         order;

  function automatic logic signed [tsp_pkg::DATA_W-1:0] scale_saturate(
      logic signed [127:0] acc);
    logic signed [127:0] sh;
    sh = acc >>> FRAC_BITS;
    if (sh > 128'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (sh < -128'sh80000000) return 32'sh80000000;
    return sh[tsp_pkg::DATA_W-1:0];
  endfunction

  task automatic form_triangle_product();
    logic signed [tsp_pkg::DATA_W-1:0] after [MAX_ORDER][MAX_ORDER];
    logic signed [127:0]               acc;
    logic signed [63:0]                prod;
    int                                n;
    n = order;
    if (n == 0 || n > MAX_ORDER) return;
    after = elements;
    for (int j = 0; j < n; j++) begin
      for (int i = 0; i < n; i++) begin
        if (!lower_mode && i > j) continue;
        if (lower_mode && i < j) continue;
        acc = '0;
        for (int k = (lower_mode ? i : j); k < n; k++) begin
          if (!lower_mode) prod = elements[i][k] * elements[j][k];
          else prod = elements[k][i] * elements[k][j];
          acc = acc + prod;
        end
        after[i][j] = scale_saturate(acc);
      end
    end
    elements = after;
  endtask

  assign pending_o = answers_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t got, want;
    if (!rst_ni) begin
      lower_mode = 1'b0;
      order = tsp_pkg::ORDER_RESET;
      fail_count_o = 0;
      answers_q.delete();
    end else begin
      if (valid_o) begin
        got.kind = kind_o;
        got.data = data_o;
        if (answers_q.size() == 0) begin
          $error("unexpected result kind=%0d data=%0d", kind_o, data_o);
          fail_count_o++;
        end else begin
          want = answers_q.pop_front();
          if (got.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, got.kind);
            fail_count_o++;
          end
          if (got.data !== want.data) begin
            $error("data: expected %0d, actual %0d", want.data, got.data);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == tsp_pkg::CFG_LOWER_MODE) lower_mode = cfg_data_i[0];
        else order = cfg_data_i[tsp_pkg::ORD_W-1:0];
      end
      if (start && !busy) begin
        case (op_i)
          tsp_pkg::OP_WRITE: elements[row_i][col_i] = value_i;
          tsp_pkg::OP_COMPUTE: begin
            form_triangle_product();
            want.kind = tsp_pkg::KIND_DONE;
            want.data = '0;
            answers_q.push_back(want);
          end
          tsp_pkg::OP_READ: begin
            want.kind = tsp_pkg::KIND_READ;
            want.data = elements[row_i][col_i];
            answers_q.push_back(want);
          end
          default: ;
        endcase
      end
    end
  end
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the testbench for the triangular self product core: clock, reset, stimulus
// and verdict. Depends on tsp_pkg, the core and tsp_checker.
module tb_top;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 500000;
  localparam int         RANDOM_ITEMS = 376;
  localparam int         FILL_ORDER = 16;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_idx_i = 1'b0;
  logic [tsp_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        op_i = tsp_pkg::OP_WRITE;
  logic [tsp_pkg::POS_W-1:0] row_i = '0;
  logic [tsp_pkg::POS_W-1:0] col_i = '0;
  logic signed [tsp_pkg::DATA_W-1:0] value_i = '0;
  logic              valid_o;
  logic              kind_o;
  logic signed [tsp_pkg::DATA_W-1:0] data_o;
  int                fail_count;
  int                pending;
  int                cycles = 0;
  int                idle_pct = 0;
  logic              written [32][32];

  triangular_self_product_core u_dut (.*);

  tsp_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start, .busy, .op_i,
    .row_i, .col_i, .value_i, .valid_o, .kind_o, .data_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic signed [tsp_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(1, 0) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return $signed($urandom_range(262143)) - 32'sd131072;
    endcase
  endfunction

  // Called at a falling edge; returns at a falling edge so items can follow back to back.
  task automatic send_item(logic [1:0] op, int row, int col,
                           logic signed [tsp_pkg::DATA_W-1:0] val);
    start = 1'b1;
    op_i = op;
    row_i = row[tsp_pkg::POS_W-1:0];
    col_i = col[tsp_pkg::POS_W-1:0];
    value_i = val;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    start = 1'b0;
    if (op == tsp_pkg::OP_WRITE) written[row][col] = 1'b1;
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [tsp_pkg::CFG_W-1:0] val);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_item();
    int pick;
    int r;
    int c;
    pick = $urandom_range(99);
    r = $urandom_range(31);
    c = $urandom_range(31);
    if (pick < 45) begin
      send_item(tsp_pkg::OP_WRITE, r, c, pick_value());
    end else if (pick < 92) begin
      if (!written[r][c]) begin
        r = r & (FILL_ORDER - 1);
        c = c & (FILL_ORDER - 1);
      end
      send_item(tsp_pkg::OP_READ, r, c, $urandom());
    end else if (pick < 96) begin
      send_item(tsp_pkg::OP_COMPUTE, r, c, $urandom());
    end else begin
      send_item(OP_UNUSED, r, c, $urandom());
    end
  endtask

  initial begin
    logic [tsp_pkg::CFG_W-1:0] orders [8] =
      '{6'd16, 6'd12, 6'd5, 6'd40, 6'd0, 6'd63, 6'd1, 6'd8};
    int phase_pct [4] = '{0, 75, 0, 6};
    for (int r = 0; r < 32; r++)
      for (int c = 0; c < 32; c++)
        written[r][c] = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < FILL_ORDER; r++)
      for (int c = 0; c < FILL_ORDER; c++)
        send_item(tsp_pkg::OP_WRITE, r, c, pick_value());

    send_item(tsp_pkg::OP_WRITE, 0, 0, 32'sh7FFFFFFF);
    send_item(tsp_pkg::OP_WRITE, 31, 31, 32'sh80000000);
    send_item(tsp_pkg::OP_WRITE, 0, 31, -32'sd1);
    send_item(tsp_pkg::OP_WRITE, 31, 0, 32'sd0);
    send_item(tsp_pkg::OP_READ, 0, 0, '0);
    send_item(tsp_pkg::OP_READ, 31, 31, '0);
    send_item(tsp_pkg::OP_READ, 0, 31, '0);
    send_item(tsp_pkg::OP_READ, 31, 0, '0);
    send_item(OP_UNUSED, 3, 4, 32'sh5A5A5A5A);
    write_reg(tsp_pkg::CFG_ORDER, 6'd16);
    send_item(tsp_pkg::OP_COMPUTE, 0, 0, '0);
    send_item(tsp_pkg::OP_READ, 0, 15, '0);
    send_item(tsp_pkg::OP_READ, 15, 0, '0);
    send_item(tsp_pkg::OP_READ, 0, 31, '0);
    write_reg(tsp_pkg::CFG_LOWER_MODE, 6'd1);
    send_item(tsp_pkg::OP_COMPUTE, 0, 0, '0);
    send_item(tsp_pkg::OP_READ, 15, 0, '0);
    write_reg(tsp_pkg::CFG_ORDER, 6'd0);
    send_item(tsp_pkg::OP_COMPUTE, 0, 0, '0);
    send_item(tsp_pkg::OP_READ, 5, 2, '0);
    write_reg(tsp_pkg::CFG_ORDER, 6'd33);
    send_item(tsp_pkg::OP_COMPUTE, 0, 0, '0);
    send_item(tsp_pkg::OP_READ, 2, 5, '0);

    for (int p = 0; p < 8; p++) begin
      write_reg(tsp_pkg::CFG_LOWER_MODE, 6'(p & 1));
      write_reg(tsp_pkg::CFG_ORDER, orders[p]);
      idle_pct = phase_pct[p % 4];
      for (int n = 0; n < RANDOM_ITEMS / 8; n++) random_item();
    end

    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
